@@ hw/rtl/akf_pkg.sv @@
// Shared constants, types and helpers of the angle Kalman filter.
package akf_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int EFF_W = (WORD_WIDTH > 32) ? 32 : WORD_WIDTH;

  localparam logic [1:0] CFG_ANGLE_Q = 2'd0;
  localparam logic [1:0] CFG_BIAS_Q = 2'd1;
  localparam logic [1:0] CFG_MEAS_R = 2'd2;

  localparam logic [30:0] ANGLE_Q_RST = 31'd1073742;
  localparam logic [30:0] BIAS_Q_RST = 31'd3221225;
  localparam logic [30:0] MEAS_R_RST = 31'd32212255;

  // Datapath operations, one per step of the sequence.
  localparam logic [3:0] OP_RATE = 4'd0;
  localparam logic [3:0] OP_ANGLE = 4'd1;
  localparam logic [3:0] OP_DTP11 = 4'd2;
  localparam logic [3:0] OP_INNER = 4'd3;
  localparam logic [3:0] OP_BIASQ = 4'd4;
  localparam logic [3:0] OP_DIV0 = 4'd5;
  localparam logic [3:0] OP_DIV1 = 4'd6;
  localparam logic [3:0] OP_CORA = 4'd7;
  localparam logic [3:0] OP_CORB = 4'd8;
  localparam logic [3:0] OP_CP00 = 4'd9;
  localparam logic [3:0] OP_CP01 = 4'd10;
  localparam logic [3:0] OP_CP10 = 4'd11;
  localparam logic [3:0] OP_CP11 = 4'd12;
  localparam logic [3:0] OP_COMMIT = 4'd13;

  typedef struct packed {
    logic load;
    logic mul_go;
    logic div_go;
    logic [3:0] op;
  } akf_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic s_pos;
  } akf_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

  function automatic logic signed [31:0] satw(input logic signed [65:0] x);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = (66'sd1 <<< (EFF_W - 1)) - 66'sd1;
    lo = -hi - 66'sd1;
    if (x > hi) begin
      satw = hi[31:0];
    end else if (x < lo) begin
      satw = lo[31:0];
    end else begin
      satw = x[31:0];
    end
  endfunction

endpackage

@@ hw/rtl/akf_mul.sv @@
// Multi-cycle signed multiplier, 33 by 35 bits, in two partial products on the low and high half.
module akf_mul import akf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [32:0] a,
  input  logic signed [34:0] b,
  output logic               done,
  output logic signed [65:0] p
);

  logic [1:0] step_r, step_nxt;
  logic signed [32:0] a_r;
  logic signed [34:0] b_r;
  logic signed [65:0] acc_r, acc_nxt;
  logic signed [65:0] part;

  always_comb begin
    if (step_r == 2'd1) begin
      part = 66'(a_r * $signed({1'b0, b_r[15:0]}));
    end else begin
      part = 66'(a_r * $signed(b_r[34:16])) <<< 16;
    end
    acc_nxt = acc_r;
    step_nxt = step_r;
    if (go) begin
      acc_nxt = '0;
      step_nxt = 2'd1;
    end else if (step_r == 2'd1) begin
      acc_nxt = part;
      step_nxt = 2'd2;
    end else if (step_r == 2'd2) begin
      acc_nxt = acc_r + part;
      step_nxt = 2'd3;
    end else if (step_r == 2'd3) begin
      step_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 2'd0;
    end else begin
      step_r <= step_nxt;
    end
    if (go) begin
      a_r <= a;
      b_r <= b;
    end
    acc_r <= acc_nxt;
  end

  assign done = (step_r == 2'd3);
  assign p = acc_r;

endmodule

@@ hw/rtl/akf_div.sv @@
// Restoring divider: quotient of a 62-bit dividend by a positive 33-bit divisor.
module akf_div import akf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [32:0] num,
  input  logic        [32:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  localparam int NB = 62;

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic        neg_r;
  logic [NB-1:0] q_r;
  logic [33:0] rem_r;
  logic [32:0] den_r;
  logic        done_r;
  logic [33:0] trial;
  logic [NB-1:0] mag;
  logic signed [63:0] sq;

  assign mag = num[32] ? NB'(-{num[31:0], 30'd0}) : NB'({num[31:0], 30'd0});
  assign trial = {rem_r[32:0], q_r[NB-1]} - {1'b0, den_r};
  assign sq = neg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r <= 6'(NB - 1);
        neg_r <= num[32];
        q_r <= mag;
        rem_r <= '0;
        den_r <= den;
      end else if (busy_r) begin
        if (!trial[33]) begin
          rem_r <= trial;
          q_r <= {q_r[NB-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[32:0], q_r[NB-1]};
          q_r <= {q_r[NB-2:0], 1'b0};
        end
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo = sat32(66'(sq));

endmodule

@@ hw/rtl/akf_datapath.sv @@
// Datapath: state registers, operand selection, rescale and saturation.
module akf_datapath import akf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  akf_cmd_t           cmd,
  output akf_sts_t           sts,
  input  logic signed [31:0] in_angle,
  input  logic signed [31:0] in_rate,
  input  logic        [23:0] in_dt,
  input  logic               cfg_we,
  input  logic        [1:0]  cfg_idx,
  input  logic        [30:0] cfg_val,
  output logic signed [31:0] angle_out
);

  logic [30:0] qa_r, qb_r, rn_r;
  logic signed [31:0] ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [31:0] ma_r, mr_r;
  logic [23:0] dt_r;
  logic signed [31:0] na_r, q00_r, q01_r, np10_r, np11_r, dtp11_r, k0_r, k1_r, y_r;
  logic signed [31:0] nb_r, c00_r, c01_r, c10_r, c11_r;
  logic signed [32:0] ma;
  logic signed [34:0] mb;
  logic signed [65:0] prod;
  logic mdone, ddone;
  logic signed [32:0] dnum;
  logic signed [32:0] s;
  logic signed [65:0] r24, r30;
  logic signed [31:0] dq;

  assign s = $signed({1'b0, rn_r}) + 33'(q00_r);
  assign r24 = (prod + 66'sd8388608) >>> 24;
  assign r30 = (prod + 66'sd536870912) >>> 30;

  always_comb begin
    ma = 33'(dt_r);
    mb = 35'(mr_r) - 35'(bias_r);
    dnum = 33'(q00_r);
    unique case (cmd.op)
      OP_DTP11: mb = 35'(p11_r);
      OP_INNER: mb = 35'(dtp11_r) - 35'(p01_r) - 35'(p10_r) + $signed({4'b0000, qa_r});
      OP_BIASQ: mb = $signed({4'b0000, qb_r});
      OP_CORA: begin ma = 33'(k0_r); mb = 35'(y_r); end
      OP_CORB: begin ma = 33'(k1_r); mb = 35'(y_r); end
      OP_CP00: begin ma = 33'(k0_r); mb = 35'(q00_r); end
      OP_CP01: begin ma = 33'(k0_r); mb = 35'(q01_r); end
      OP_CP10: begin ma = 33'(k1_r); mb = 35'(q00_r); end
      OP_CP11: begin ma = 33'(k1_r); mb = 35'(q01_r); end
      OP_DIV1: dnum = 33'(np10_r);
      default: ;
    endcase
  end

  akf_mul u_mul (
    .clk(clk), .rst_n(rst_n), .go(cmd.mul_go), .a(ma), .b(mb), .done(mdone), .p(prod)
  );

  akf_div u_div (
    .clk(clk), .rst_n(rst_n), .go(cmd.div_go), .num(dnum), .den(s[32:0]),
    .done(ddone), .quo(dq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_r <= ANGLE_Q_RST;
      qb_r <= BIAS_Q_RST;
      rn_r <= MEAS_R_RST;
      ang_r <= '0;
      bias_r <= '0;
      p00_r <= '0;
      p01_r <= '0;
      p10_r <= '0;
      p11_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_ANGLE_Q: qa_r <= cfg_val;
          CFG_BIAS_Q: qb_r <= cfg_val;
          CFG_MEAS_R: rn_r <= (cfg_val == '0) ? 31'd1 : cfg_val;
          default: ;
        endcase
      end
      if (cmd.op == OP_COMMIT && cmd.load) begin
        ang_r <= nb_r;
        if (s > 0) begin
          bias_r <= c11_r;
          p00_r <= c00_r;
          p01_r <= c01_r;
          p10_r <= c10_r;
          p11_r <= k1_r;
        end else begin
          p00_r <= q00_r;
          p01_r <= q01_r;
          p10_r <= np10_r;
          p11_r <= np11_r;
        end
      end
    end
  end

  // Scratch registers; the commit step writes the state from them.
  always_ff @(posedge clk) begin
    if (cmd.load && cmd.op == OP_RATE) begin
      ma_r <= in_angle;
      mr_r <= in_rate;
      dt_r <= in_dt;
    end
    if (mdone) begin
      unique case (cmd.op)
        OP_ANGLE: na_r <= satw(66'(ang_r) + r24);
        OP_DTP11: begin
          dtp11_r <= sat32(r24);
          q01_r <= sat32(66'(p01_r) - r24);
          np10_r <= sat32(66'(p10_r) - r24);
        end
        OP_INNER: q00_r <= sat32(66'(p00_r) + r24);
        OP_BIASQ: np11_r <= sat32(66'(p11_r) + r24);
        OP_CORA: nb_r <= satw(66'(na_r) + r30);
        OP_CORB: c11_r <= satw(66'(bias_r) + r30);
        OP_CP00: c00_r <= sat32(66'(q00_r) - r30);
        OP_CP01: c01_r <= sat32(66'(q01_r) - r30);
        OP_CP10: c10_r <= sat32(66'(np10_r) - r30);
        OP_CP11: k1_r <= sat32(66'(np11_r) - r30);
        default: ;
      endcase
    end
    if (ddone) begin
      if (cmd.op == OP_DIV0) begin
        k0_r <= dq;
        y_r <= sat32(66'(ma_r) - 66'(na_r));
      end else begin
        k1_r <= dq;
      end
    end
    if (cmd.op == OP_CORA && !(s > 0)) begin
      nb_r <= na_r;
    end
  end

  assign sts.mul_done = mdone;
  assign sts.div_done = ddone;
  assign sts.s_pos = (s > 0);
  assign angle_out = ang_r;

endmodule

@@ hw/rtl/akf_ctrl.sv @@
// Controller: steps the datapath through one filter update per beat.
module akf_ctrl import akf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_free,
  input  akf_sts_t sts,
  output akf_cmd_t cmd,
  output logic     busy,
  output logic     result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic [3:0] op_r, op_nxt;
  logic is_div;
  logic skip;

  assign is_div = (op_r == OP_DIV0) || (op_r == OP_DIV1);
  assign skip = !sts.s_pos && (op_r >= OP_DIV0) && (op_r <= OP_CP11);

  always_comb begin
    st_nxt = st_r;
    op_nxt = op_r;
    cmd = '0;
    cmd.op = op_r;
    result = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.op = OP_RATE;
          cmd.load = 1'b1;
          op_nxt = OP_ANGLE;
          st_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (op_r == OP_COMMIT) begin
          if (out_free) begin
            cmd.load = 1'b1;
            st_nxt = ST_DONE;
          end
        end else if (skip) begin
          if (op_r == OP_CORA) begin
            cmd.load = 1'b1;
          end
          op_nxt = op_r + 4'd1;
        end else begin
          cmd.mul_go = !is_div;
          cmd.div_go = is_div;
          st_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (is_div ? sts.div_done : sts.mul_done) begin
          op_nxt = op_r + 4'd1;
          st_nxt = ST_ISSUE;
        end
      end
      ST_DONE: begin
        result = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      op_r <= OP_RATE;
    end else begin
      st_r <= st_nxt;
      op_r <= op_nxt;
    end
  end

  assign busy = (st_r != ST_IDLE);

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_fire) else $error("beat taken while busy");
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mul_go && cmd.div_go)) else $error("two units started");
  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE) |=> (st_r == ST_IDLE)) else $error("done not closed");

endmodule

@@ hw/rtl/angle_kalman_filter.sv @@
// Top level of the two-state angle and gyro bias Kalman filter.
//  port group | dir | content
//  in_*       | in  | measured angle, rate and time step
//  out_*      | out | filtered angle
//  cfg_*      | in  | noise registers 0 to 2
// A beat runs from acceptance to the next free input slot through ten products
// on the shared multiplier, two gain divisions, the commit and the result.
// With a non-positive innovation covariance the gain and correction steps are
// skipped. Reset is synchronous and clears the estimates and covariance. The
// commit waits while the output register holds an unsent beat; the next beat
// is taken once idle.
module angle_kalman_filter import akf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // measured_angle[31:0], measured_rate[63:32], time_step[87:64]
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // filtered_angle[31:0]
  output logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  akf_cmd_t cmd;
  akf_sts_t sts;
  logic busy, result, in_fire;
  logic ov_r;
  logic [31:0] od_r;
  logic signed [31:0] ang;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;

  akf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(!ov_r || out_tready),
    .sts(sts), .cmd(cmd), .busy(busy), .result(result)
  );

  akf_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_angle(in_tdata[31:0]), .in_rate(in_tdata[63:32]), .in_dt(in_tdata[87:64]),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_val(cfg_data), .angle_out(ang)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (result) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
    if (result) begin
      od_r <= ang;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;

endmodule
